[sv/fhx_pkg.sv]
// ----------------------------------------------------------------------------
// fhx_pkg: shared types and constants for the hex-float text formatter
// Character codes, controller states, datapath command and status records.
// ----------------------------------------------------------------------------
package fhx_pkg;

    localparam int RAW_W  = 64;
    localparam int CHAR_W = 8;
    localparam int FRAC_W = 52;
    localparam int EXP_W  = 11;
    localparam int MAG_W  = 10;
    localparam int PLC_W  = 2;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIGN,
        S_SPEC,
        S_ZERO,
        S_X,
        S_LEAD,
        S_DOT,
        S_FRAC,
        S_P,
        S_ESIGN,
        S_DIGIT
    } t_fhx_state;

    typedef enum logic [3:0] {
        SEL_MINUS,
        SEL_SPEC,
        SEL_ZERO,
        SEL_X,
        SEL_LEAD,
        SEL_DOT,
        SEL_NIB,
        SEL_P,
        SEL_ESIGN,
        SEL_DIGIT
    } t_fhx_sel;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       last;
        t_fhx_sel   sel;
        logic [1:0] spec_idx;
        logic       frac_shift;
        logic       exp_step;
    } t_fhx_cmd;

    typedef struct packed {
        logic out_free;
        logic neg;
        logic exp_ones;
        logic frac_zero;
        logic rest_zero;
        logic last_place;
    } t_fhx_stat;

endpackage

[sv/fhx_if.sv]
// ----------------------------------------------------------------------------
// fhx_in_if / fhx_out_if: valid-ready channels of the formatter
// Input carries one float bit pattern, output carries one character.
// ----------------------------------------------------------------------------
interface fhx_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_bits;
    logic        is_double;

    modport source (output valid, output raw_bits, output is_double, input ready);
    modport sink   (input valid, input raw_bits, input is_double, output ready);
endinterface

interface fhx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_char;

    modport source (output valid, output char_out, output last_char, input ready);
    modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

[sv/fhx_ctrl.sv]
// ----------------------------------------------------------------------------
// fhx_ctrl: formatter sequencer
// Walks through the fields of the text and commands one character per step.
// ----------------------------------------------------------------------------
module fhx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fhx_pkg::t_fhx_stat i_stat,
    output fhx_pkg::t_fhx_cmd  o_cmd
);
    import fhx_pkg::*;

    t_fhx_state r_state, n_state;
    logic [1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.last       = 1'b0;
        o_cmd.sel        = SEL_MINUS;
        o_cmd.spec_idx   = r_cnt;
        o_cmd.frac_shift = 1'b0;
        o_cmd.exp_step   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SIGN;
                end
            end
            S_SIGN: begin
                // A positive value starts directly with its first body character.
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.neg) begin
                        o_cmd.sel = SEL_MINUS;
                        n_state   = i_stat.exp_ones ? S_SPEC : S_ZERO;
                    end else if (i_stat.exp_ones) begin
                        o_cmd.sel = SEL_SPEC;
                        n_cnt     = 2'd1;
                        n_state   = S_SPEC;
                    end else begin
                        o_cmd.sel = SEL_ZERO;
                        n_state   = S_X;
                    end
                end
            end
            S_SPEC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SPEC;
                    if (r_cnt == 2'd2) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            S_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_ZERO;
                    n_state    = S_X;
                end
            end
            S_X: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_X;
                    n_state    = S_LEAD;
                end
            end
            S_LEAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_LEAD;
                    n_state    = i_stat.frac_zero ? S_P : S_DOT;
                end
            end
            S_DOT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_DOT;
                    n_state    = S_FRAC;
                end
            end
            S_FRAC: begin
                // Nibbles go out until only zero nibbles remain below.
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.sel        = SEL_NIB;
                    o_cmd.frac_shift = 1'b1;
                    if (i_stat.rest_zero) begin
                        n_state = S_P;
                    end
                end
            end
            S_P: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_P;
                    n_state    = S_ESIGN;
                end
            end
            S_ESIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_ESIGN;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.sel      = SEL_DIGIT;
                    o_cmd.exp_step = 1'b1;
                    if (i_stat.last_place) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/fhx_dp.sv]
// ----------------------------------------------------------------------------
// fhx_dp: formatter datapath
// Field decode, fraction nibble shifter, decimal exponent digits, output register.
// ----------------------------------------------------------------------------
module fhx_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [fhx_pkg::RAW_W-1:0]         i_raw_bits,
    input  logic                              i_is_double,
    input  fhx_pkg::t_fhx_cmd                 i_cmd,
    output fhx_pkg::t_fhx_stat                o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [fhx_pkg::CHAR_W-1:0]        o_char_out,
    output logic                              o_last_char
);
    import fhx_pkg::*;

    localparam logic [EXP_W-1:0] D_ONES = 11'h7FF;
    localparam logic [EXP_W-1:0] D_BIAS = 11'h3FF;
    localparam logic [EXP_W-1:0] S_ONES = 11'h0FF;
    localparam logic [EXP_W-1:0] S_BIAS = 11'h07F;
    localparam logic [13:0] POW10 [4] = '{14'd1, 14'd10, 14'd100, 14'd1000};

    // Decoded value
    logic              r_neg, r_exp_ones, r_exp_zero, r_eneg;
    logic [FRAC_W-1:0] r_frac;
    logic [MAG_W-1:0]  r_mag;
    logic [PLC_W-1:0]  r_place;

    // Output register
    logic              r_ovalid, r_olast;
    logic [CHAR_W-1:0] r_ochar;

    logic              d_neg;
    logic [EXP_W-1:0]  d_expf, d_ones, d_bias, d_diff;
    logic [FRAC_W-1:0] d_frac;
    logic              d_eneg;
    logic [MAG_W-1:0]  d_mag;
    logic [PLC_W-1:0]  d_place;

    logic [3:0]        dig;
    logic [13:0]       dig_sub;
    logic [13:0]       kp;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] ch;
    logic              out_free;

    always_comb begin
        if (i_is_double) begin
            d_neg  = i_raw_bits[63];
            d_expf = i_raw_bits[62:52];
            d_frac = i_raw_bits[51:0];
            d_ones = D_ONES;
            d_bias = D_BIAS;
        end else begin
            // Single fraction is shown as six nibbles, left aligned.
            d_neg  = i_raw_bits[31];
            d_expf = {3'b000, i_raw_bits[30:23]};
            d_frac = {i_raw_bits[22:0], 29'd0};
            d_ones = S_ONES;
            d_bias = S_BIAS;
        end
        if (d_expf == '0) begin
            d_eneg = 1'b0;
            d_diff = '0;
        end else if (d_expf >= d_bias) begin
            d_eneg = 1'b0;
            d_diff = d_expf - d_bias;
        end else begin
            d_eneg = 1'b1;
            d_diff = d_bias - d_expf;
        end
        d_mag = d_diff[MAG_W-1:0];
        if (d_mag >= 10'd1000) begin
            d_place = 2'd3;
        end else if (d_mag >= 10'd100) begin
            d_place = 2'd2;
        end else if (d_mag >= 10'd10) begin
            d_place = 2'd1;
        end else begin
            d_place = 2'd0;
        end
    end

    // One decimal digit per step: largest multiple of the place weight that fits.
    always_comb begin
        dig     = '0;
        dig_sub = '0;
        kp      = '0;
        for (int k = 1; k <= 9; k++) begin
            kp = POW10[r_place] * 14'(k);
            if ({4'd0, r_mag} >= kp) begin
                dig     = 4'(k);
                dig_sub = kp;
            end
        end
    end

    assign nib      = r_frac[FRAC_W-1 -: 4];
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        case (i_cmd.sel)
            SEL_MINUS: ch = CH_MINUS;
            SEL_SPEC: begin
                case (i_cmd.spec_idx)
                    2'd0:    ch = (r_frac == '0) ? CH_I : CH_N;
                    2'd1:    ch = (r_frac == '0) ? CH_N : CH_A;
                    default: ch = (r_frac == '0) ? CH_F : CH_N;
                endcase
            end
            SEL_ZERO:  ch = CH_ZERO;
            SEL_X:     ch = CH_X;
            SEL_LEAD:  ch = r_exp_zero ? CH_ZERO : CH_ONE;
            SEL_DOT:   ch = CH_DOT;
            SEL_NIB:   ch = (nib < 4'd10) ? (CH_ZERO + {4'd0, nib})
                                          : (CH_A + {4'd0, nib} - 8'd10);
            SEL_P:     ch = CH_P;
            SEL_ESIGN: ch = r_eneg ? CH_MINUS : CH_PLUS;
            SEL_DIGIT: ch = CH_ZERO + {4'd0, dig};
            default:   ch = CH_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg      <= d_neg;
            r_exp_ones <= (d_expf == d_ones);
            r_exp_zero <= (d_expf == '0);
            r_frac     <= d_frac;
            r_eneg     <= d_eneg;
            r_mag      <= d_mag;
            r_place    <= d_place;
        end else begin
            if (i_cmd.frac_shift) begin
                r_frac <= {r_frac[FRAC_W-5:0], 4'd0};
            end
            if (i_cmd.exp_step) begin
                r_mag   <= r_mag - dig_sub[MAG_W-1:0];
                r_place <= r_place - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ochar <= ch;
            r_olast <= i_cmd.last;
        end
    end

    assign o_stat.out_free   = out_free;
    assign o_stat.neg        = r_neg;
    assign o_stat.exp_ones   = r_exp_ones;
    assign o_stat.frac_zero  = (r_frac == '0);
    assign o_stat.rest_zero  = (r_frac[FRAC_W-5:0] == '0);
    assign o_stat.last_place = (r_place == '0);

    assign o_out_valid = r_ovalid;
    assign o_char_out  = r_ochar;
    assign o_last_char = r_olast;

endmodule

[sv/float_to_hex_text_core.sv]
// After the transfer in, the decoded fields are registered, then the first character is written to the
// output register once it is free. Throughput: one character per cycle while the output is ready;
// a value has at most 24 characters, all sent through the single output character port.
// A new value is taken while the last character of the previous one waits.
// Reset (synchronous, active low) clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// float_to_hex_text_core: IEEE-754 hexadecimal float text formatter
// Turns a single or double bit pattern into a stream of ASCII characters.
// ----------------------------------------------------------------------------
module float_to_hex_text_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fhx_in_if.sink     i_in,
    fhx_out_if.source  o_out
);
    import fhx_pkg::*;

    t_fhx_cmd  cmd;
    t_fhx_stat stat;
    logic      in_ready;

    fhx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fhx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw_bits  (i_in.raw_bits),
        .i_is_double (i_in.is_double),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_char_out  (o_out.char_out),
        .o_last_char (o_out.last_char)
    );

    assign i_in.ready = in_ready;

    // Only one value is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while a value is still being formatted");

    // While idle, a pending character can only be the end of the previous value.
    a_idle_pending_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready && o_out.valid |-> o_out.last_char)
        else $error("idle with an unfinished character sequence");

    // Text always ends with inf, nan or an exponent digit.
    a_last_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_char |->
            (o_out.char_out == CH_F) || (o_out.char_out == CH_N) ||
            ((o_out.char_out >= CH_ZERO) && (o_out.char_out <= CH_NINE)))
        else $error("final character is not a valid terminator");

endmodule
